/* rtl/mnsl_pkg.sv */
// Shared types, constants and the controller decode for the MIDI note and switch linker.
`default_nettype none
package mnsl_pkg;

    // Sizing
    localparam int STACK_DEPTH = 4;
    localparam int INDEX_WIDTH = 16;
    localparam int CHANNELS    = 16;
    localparam int KEYS        = 128;
    localparam int NOTE_SLOTS  = CHANNELS * KEYS;
    localparam int NOTE_AW     = $clog2(NOTE_SLOTS);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int STORE_DEPTH = NOTE_SLOTS * STACK_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SW_NUM      = 18;
    localparam int SW_NUM_W    = $clog2(SW_NUM);
    localparam int SW_SLOTS    = SW_NUM * CHANNELS;
    localparam int SW_AW       = $clog2(SW_SLOTS);
    localparam int CHAN_W      = $clog2(CHANNELS);

    // Status types (high nibble)
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_CTRL     = 4'hB;

    // Switch controller ranges and threshold
    localparam logic [6:0] SW_THRESHOLD = 7'd64;
    localparam logic [6:0] SW_A_LO      = 7'd64;
    localparam logic [6:0] SW_A_HI      = 7'd69;
    localparam logic [6:0] SW_B_LO      = 7'd80;
    localparam logic [6:0] SW_B_HI      = 7'd90;
    localparam logic [6:0] SW_C_CTL     = 7'd122;
    localparam logic [SW_NUM_W-1:0] SW_B_BASE = SW_NUM_W'(6);
    localparam logic [SW_NUM_W-1:0] SW_C_NUM  = SW_NUM_W'(17);

    // Result kinds
    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_POP
    } state_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_ON,
        EV_OFF,
        EV_SW
    } ev_t;

    typedef enum logic [1:0] {
        SW_UNKNOWN,
        SW_OFF,
        SW_ON
    } sw_state_t;

    typedef struct packed {
        sw_state_t              st;
        logic [INDEX_WIDTH-1:0] opener;
    } sw_entry_t;

    typedef struct packed {
        logic                hit;
        logic [SW_NUM_W-1:0] num;
    } sw_map_t;

    // Map a controller number onto its switch number, if it is one.
    function automatic sw_map_t sw_map(input logic [6:0] ctl);
        sw_map_t r;
        r.hit = 1'b0;
        r.num = '0;
        if (ctl >= SW_A_LO && ctl <= SW_A_HI) begin
            r.hit = 1'b1;
            r.num = SW_NUM_W'(ctl - SW_A_LO);
        end else if (ctl >= SW_B_LO && ctl <= SW_B_HI) begin
            r.hit = 1'b1;
            r.num = SW_NUM_W'(ctl - SW_B_LO) + SW_B_BASE;
        end else if (ctl == SW_C_CTL) begin
            r.hit = 1'b1;
            r.num = SW_C_NUM;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/midi_note_and_switch_linker.sv */
// Top level of the MIDI note and switch linker: event decode, state memories and result register.
`default_nettype none
// Pairs time-ordered MIDI events. For each accepted event (op 0) the transfer cycle
// issues reads of the per channel/key stack fill memory and the switch memory, and
// the next cycle resolves the event and writes back. A note-off that finds a stacked
// note-on then enters a pop state for the read of the note stack memory. Results go
// into an output register, so an event is taken while a result waits; the block
// stalls only when a new result is due and the register is still full. A clear (op 1)
// and reset both start a clearing pass over all 2048 fill memory entries (which also
// clears the 288 switch entries) during which s_ready stays low. Memories are
// single-port with registered reads; one event is in flight at a time, so a
// write-back always lands before the next event's read.
module midi_note_and_switch_linker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [15:0] s_event_index,
    input  wire logic [7:0]  s_status_byte,
    input  wire logic [6:0]  s_data_one,
    input  wire logic [6:0]  s_data_two,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_first_index,
    output logic [15:0]      m_second_index,
    output logic [1:0]       m_link_kind,
    output logic [15:0]      m_pair_count
);

    localparam int IW = mnsl_pkg::INDEX_WIDTH;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic [IW-1:0]                  store_mem [mnsl_pkg::STORE_DEPTH];
    logic [mnsl_pkg::FILL_W-1:0]    fill_mem  [mnsl_pkg::NOTE_SLOTS];
    mnsl_pkg::sw_entry_t            sw_mem    [mnsl_pkg::SW_SLOTS];

    // ---------------------------------------------------------------
    // Control and captured event
    // ---------------------------------------------------------------
    mnsl_pkg::state_t               state_reg, state_next;
    logic [mnsl_pkg::NOTE_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    mnsl_pkg::ev_t                  ev_reg;
    logic [IW-1:0]                  idx_reg;
    logic [mnsl_pkg::NOTE_AW-1:0]   note_slot_reg;
    logic [mnsl_pkg::SW_AW-1:0]     sw_addr_reg;
    logic                           sw_on_reg;
    logic [mnsl_pkg::FILL_W-1:0]    fill_rd_reg;
    mnsl_pkg::sw_entry_t            sw_rd_reg;
    logic [IW-1:0]                  store_rd_reg;
    logic [15:0]                    pair_total_reg;

    // Output register
    logic                           m_valid_reg;
    logic [15:0]                    m_first_reg;
    logic [15:0]                    m_second_reg;
    logic [1:0]                     m_kind_reg;
    logic [15:0]                    m_count_reg;

    // ---------------------------------------------------------------
    // Input decode (from ports, used at the transfer edge)
    // ---------------------------------------------------------------
    logic                           in_accept;
    logic [3:0]                     in_type;
    logic [mnsl_pkg::CHAN_W-1:0]    in_chan;
    mnsl_pkg::sw_map_t              in_sw;
    mnsl_pkg::ev_t                  in_ev;
    logic [mnsl_pkg::NOTE_AW-1:0]   in_note_slot;
    logic [mnsl_pkg::SW_AW-1:0]     in_sw_addr;

    assign in_accept    = s_valid && s_ready;
    assign in_type      = s_status_byte[7:4];
    assign in_chan      = s_status_byte[3:0];
    assign in_sw        = mnsl_pkg::sw_map(s_data_one);
    assign in_note_slot = {in_chan, s_data_one};
    assign in_sw_addr   = mnsl_pkg::SW_AW'(in_sw.num) * mnsl_pkg::SW_AW'(mnsl_pkg::CHANNELS)
                        + mnsl_pkg::SW_AW'(in_chan);

    always_comb begin
        in_ev = mnsl_pkg::EV_NONE;
        if (in_type == mnsl_pkg::TYPE_NOTE_ON && s_data_two != 7'd0) begin
            in_ev = mnsl_pkg::EV_ON;
        end else if (in_type == mnsl_pkg::TYPE_NOTE_OFF || in_type == mnsl_pkg::TYPE_NOTE_ON) begin
            in_ev = mnsl_pkg::EV_OFF;
        end else if (in_type == mnsl_pkg::TYPE_CTRL && in_sw.hit) begin
            in_ev = mnsl_pkg::EV_SW;
        end
    end

    // ---------------------------------------------------------------
    // Resolve-cycle conditions
    // ---------------------------------------------------------------
    logic out_ok;
    logic note_full;
    logic note_empty;
    logic sw_is_on;
    logic exec_emit;
    logic clr_last;

    assign out_ok     = !m_valid_reg || m_ready;
    assign note_full  = fill_rd_reg >= mnsl_pkg::FILL_W'(mnsl_pkg::STACK_DEPTH);
    assign note_empty = fill_rd_reg == '0;
    assign sw_is_on   = sw_rd_reg.st == mnsl_pkg::SW_ON;
    assign exec_emit  = (state_reg == mnsl_pkg::ST_EXEC)
                     && ((ev_reg == mnsl_pkg::EV_ON && note_full)
                      || (ev_reg == mnsl_pkg::EV_SW && !sw_on_reg && sw_is_on));
    assign clr_last   = clr_cnt_reg == mnsl_pkg::NOTE_AW'(mnsl_pkg::NOTE_SLOTS - 1);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            mnsl_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last) begin
                    state_next = mnsl_pkg::ST_IDLE;
                end
            end
            mnsl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    clr_cnt_next = '0;
                    state_next   = s_op ? mnsl_pkg::ST_CLEAR : mnsl_pkg::ST_EXEC;
                end
            end
            mnsl_pkg::ST_EXEC: begin
                if (exec_emit && !out_ok) begin
                    state_next = mnsl_pkg::ST_EXEC;
                end else if (ev_reg == mnsl_pkg::EV_OFF && !note_empty) begin
                    state_next = mnsl_pkg::ST_POP;
                end else begin
                    state_next = mnsl_pkg::ST_IDLE;
                end
            end
            mnsl_pkg::ST_POP: begin
                if (out_ok) begin
                    state_next = mnsl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mnsl_pkg::ST_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Memory write-back, result load
    // ---------------------------------------------------------------
    logic                           fill_we;
    logic [mnsl_pkg::NOTE_AW-1:0]   fill_waddr;
    logic [mnsl_pkg::FILL_W-1:0]    fill_wdata;
    logic                           sw_we;
    logic [mnsl_pkg::SW_AW-1:0]     sw_waddr;
    mnsl_pkg::sw_entry_t            sw_wdata;
    logic                           store_we;
    logic                           store_re;
    logic [mnsl_pkg::STORE_AW-1:0]  store_addr;
    logic                           out_load;
    logic [15:0]                    out_first;
    logic [1:0]                     out_kind;
    logic                           pair_inc;
    logic                           pair_clr;
    logic [mnsl_pkg::FILL_W-1:0]    fill_dec;

    assign fill_dec = fill_rd_reg - 1'b1;

    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = note_slot_reg;
        fill_wdata = fill_rd_reg + 1'b1;
        sw_we      = 1'b0;
        sw_waddr   = sw_addr_reg;
        sw_wdata   = '{st: mnsl_pkg::SW_ON, opener: idx_reg};
        store_we   = 1'b0;
        store_re   = 1'b0;
        store_addr = mnsl_pkg::STORE_AW'(note_slot_reg)
                   * mnsl_pkg::STORE_AW'(mnsl_pkg::STACK_DEPTH)
                   + mnsl_pkg::STORE_AW'(fill_rd_reg);
        out_load   = 1'b0;
        out_first  = '0;
        out_kind   = mnsl_pkg::KIND_NOTE;
        pair_inc   = 1'b0;
        pair_clr   = 1'b0;
        case (state_reg)
            mnsl_pkg::ST_CLEAR: begin
                // Sweep the fill memory; the switch memory rides along for its lower entries.
                fill_we    = 1'b1;
                fill_waddr = clr_cnt_reg;
                fill_wdata = '0;
                sw_we      = clr_cnt_reg < mnsl_pkg::NOTE_AW'(mnsl_pkg::SW_SLOTS);
                sw_waddr   = clr_cnt_reg[mnsl_pkg::SW_AW-1:0];
                sw_wdata   = '{st: mnsl_pkg::SW_UNKNOWN, opener: '0};
                pair_clr   = 1'b1;
            end
            mnsl_pkg::ST_EXEC: begin
                case (ev_reg)
                    mnsl_pkg::EV_ON: begin
                        if (note_full) begin
                            // Drop the note-on and flag it.
                            out_load = out_ok;
                            out_kind = mnsl_pkg::KIND_DROP;
                        end else begin
                            store_we = 1'b1;
                            fill_we  = 1'b1;
                        end
                    end
                    mnsl_pkg::EV_OFF: begin
                        if (!note_empty) begin
                            fill_we    = 1'b1;
                            fill_wdata = fill_dec;
                            store_re   = 1'b1;
                            store_addr = mnsl_pkg::STORE_AW'(note_slot_reg)
                                       * mnsl_pkg::STORE_AW'(mnsl_pkg::STACK_DEPTH)
                                       + mnsl_pkg::STORE_AW'(fill_dec);
                        end
                    end
                    mnsl_pkg::EV_SW: begin
                        if (sw_on_reg) begin
                            sw_we = !sw_is_on;
                        end else if (sw_is_on) begin
                            sw_we     = out_ok;
                            sw_wdata  = '{st: mnsl_pkg::SW_OFF, opener: idx_reg};
                            out_load  = out_ok;
                            out_first = sw_rd_reg.opener;
                            out_kind  = mnsl_pkg::KIND_CTRL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mnsl_pkg::ST_POP: begin
                out_load  = out_ok;
                out_first = store_rd_reg;
                out_kind  = mnsl_pkg::KIND_NOTE;
                pair_inc  = out_ok;
            end
            default: begin
            end
        endcase
    end

    logic [15:0] pair_next;
    assign pair_next = (pair_inc && pair_total_reg != 16'hFFFF) ? pair_total_reg + 16'd1
                                                                : pair_total_reg;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mnsl_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            pair_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pair_total_reg <= pair_clr ? 16'd0 : pair_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the event at its transfer.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ev_reg        <= in_ev;
            idx_reg       <= s_event_index;
            note_slot_reg <= in_note_slot;
            sw_addr_reg   <= in_sw_addr;
            sw_on_reg     <= s_data_two >= mnsl_pkg::SW_THRESHOLD;
        end
        if (out_load) begin
            m_first_reg  <= out_first;
            m_second_reg <= idx_reg;
            m_kind_reg   <= out_kind;
            m_count_reg  <= pair_next;
        end
    end

    // Fill memory: read at transfer, write back in the resolve cycle or the sweep.
    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (in_accept) begin
            fill_rd_reg <= fill_mem[in_note_slot];
        end
    end

    // Switch memory.
    always_ff @(posedge aclk) begin
        if (sw_we) begin
            sw_mem[sw_waddr] <= sw_wdata;
        end
        if (in_accept) begin
            sw_rd_reg <= sw_mem[in_sw_addr];
        end
    end

    // Note stack memory: push writes, pop reads, never both in one cycle.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_addr] <= idx_reg;
        end
        if (store_re) begin
            store_rd_reg <= store_mem[store_addr];
        end
    end

    assign s_ready        = state_reg == mnsl_pkg::ST_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_first_index  = m_first_reg;
    assign m_second_index = m_second_reg;
    assign m_link_kind    = m_kind_reg;
    assign m_pair_count   = m_count_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_we |-> (fill_wdata <= mnsl_pkg::FILL_W'(mnsl_pkg::STACK_DEPTH)))
        else $error("stack fill written beyond depth");

    a_note_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_kind == mnsl_pkg::KIND_NOTE) |-> (pair_next != 16'd0))
        else $error("note link with zero pair count");

    a_store_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(store_we && store_re))
        else $error("stack memory read and written in one cycle");

    a_pop_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mnsl_pkg::ST_POP && $past(state_reg) != mnsl_pkg::ST_POP)
            |-> $past(store_re))
        else $error("pop without a stack read");

endmodule
`default_nettype wire

/* sim/link_check_pkg.sv */
// Scoreboard class that predicts and checks the links of the MIDI note and switch linker.
package link_check_pkg;
    import mnsl_pkg::*;

    typedef struct packed {
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic [1:0]  link_kind;
        logic [15:0] pair_count;
    } link_t;

    class link_scoreboard;
        logic [INDEX_WIDTH-1:0] note_stack [NOTE_SLOTS][STACK_DEPTH];
        int unsigned            stack_fill [NOTE_SLOTS];
        sw_state_t              switch_st [SW_SLOTS];
        logic [INDEX_WIDTH-1:0] switch_opener [SW_SLOTS];
        logic [15:0]            pairs_linked;
        link_t                  pending_links [$];
        int unsigned            mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        // Empty all stacks and switches; stored indices are only read after a write.
        function void wipe();
            foreach (stack_fill[i]) stack_fill[i] = 0;
            foreach (switch_st[i]) switch_st[i] = SW_UNKNOWN;
            pairs_linked = '0;
        endfunction

        function bit switch_number(input logic [6:0] ctl, output int num);
            num = 0;
            if (ctl >= SW_A_LO && ctl <= SW_A_HI) begin
                num = int'(ctl) - int'(SW_A_LO);
                return 1'b1;
            end
            if (ctl >= SW_B_LO && ctl <= SW_B_HI) begin
                num = int'(ctl) - int'(SW_B_LO) + int'(SW_B_BASE);
                return 1'b1;
            end
            if (ctl == SW_C_CTL) begin
                num = int'(SW_C_NUM);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void queue_link(logic [15:0] first, logic [15:0] second, logic [1:0] kind);
            link_t link;
            link.first_index  = first;
            link.second_index = second;
            link.link_kind    = kind;
            link.pair_count   = pairs_linked;
            pending_links = {pending_links, link};
        endfunction

        // Advance the predicted state by one accepted transfer.
        function void note_event(logic op, logic [15:0] idx, logic [7:0] status,
                                 logic [6:0] d1, logic [6:0] d2);
            logic [3:0] kind_nib;
            int         slot;
            int         fill;
            int         num;
            kind_nib = status[7:4];
            if (op) begin
                wipe();
                return;
            end
            slot = int'({status[3:0], d1});
            if (kind_nib == TYPE_NOTE_ON && d2 != 7'd0) begin
                fill = stack_fill[slot];
                if (fill >= STACK_DEPTH) begin
                    queue_link('0, idx, KIND_DROP);
                end else begin
                    note_stack[slot][fill] = idx;
                    stack_fill[slot] = fill + 1;
                end
            end else if (kind_nib == TYPE_NOTE_OFF || kind_nib == TYPE_NOTE_ON) begin
                if (stack_fill[slot] != 0) begin
                    fill = stack_fill[slot] - 1;
                    stack_fill[slot] = fill;
                    if (pairs_linked != '1) pairs_linked++;
                    queue_link(note_stack[slot][fill], idx, KIND_NOTE);
                end
            end else if (kind_nib == TYPE_CTRL && switch_number(d1, num)) begin
                slot = num * CHANNELS + int'(status[3:0]);
                if (d2 >= SW_THRESHOLD) begin
                    if (switch_st[slot] != SW_ON) begin
                        switch_st[slot] = SW_ON;
                        switch_opener[slot] = idx;
                    end
                end else if (switch_st[slot] == SW_ON) begin
                    queue_link(switch_opener[slot], idx, KIND_CTRL);
                    switch_st[slot] = SW_OFF;
                    switch_opener[slot] = idx;
                end
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_link(logic [15:0] first, logic [15:0] second, logic [1:0] kind,
                        logic [15:0] count);
            link_t want;
            if (pending_links.size() == 0) begin
                flag_mismatch($sformatf("unexpected link %h %h kind %0d count %0d",
                                        first, second, kind, count));
                return;
            end
            want = pending_links.pop_front();
            if (first !== want.first_index)
                flag_mismatch($sformatf("first_index %h, want %h", first, want.first_index));
            if (second !== want.second_index)
                flag_mismatch($sformatf("second_index %h, want %h", second, want.second_index));
            if (kind !== want.link_kind)
                flag_mismatch($sformatf("link_kind %0d, want %0d", kind, want.link_kind));
            if (count !== want.pair_count)
                flag_mismatch($sformatf("pair_count %0d, want %0d", count, want.pair_count));
        endtask

        task check_drained();
            if (pending_links.size() != 0)
                flag_mismatch($sformatf("%0d links never arrived", pending_links.size()));
        endtask
    endclass

endpackage

/* sim/tb_top.sv */
// Testbench top for the MIDI note and switch linker: directed and random streams.
module tb_top;
    import mnsl_pkg::*;
    import link_check_pkg::*;

    // Status types the block ignores
    localparam logic [3:0] TYPE_DATA       = 4'h0;
    localparam logic [3:0] TYPE_PITCH_BEND = 4'hE;
    localparam logic [3:0] TYPE_SYSTEM     = 4'hF;

    localparam int NOTE_KEY_HOLD = 60;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_op           = 1'b0;
    logic [15:0] s_event_index  = '0;
    logic [7:0]  s_status_byte  = '0;
    logic [6:0]  s_data_one     = '0;
    logic [6:0]  s_data_two     = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_first_index;
    logic [15:0] m_second_index;
    logic [1:0]  m_link_kind;
    logic [15:0] m_pair_count;

    // Random gaps on both channels while set; cleared for stretches of back-to-back traffic.
    bit idle_on = 1'b1;

    link_scoreboard sb = new();

    always #5 aclk = ~aclk;

    midi_note_and_switch_linker uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_event_index  (s_event_index),
        .s_status_byte  (s_status_byte),
        .s_data_one     (s_data_one),
        .s_data_two     (s_data_two),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_index  (m_first_index),
        .m_second_index (m_second_index),
        .m_link_kind    (m_link_kind),
        .m_pair_count   (m_pair_count)
    );

    // Drive one event. Call at a falling edge; returns at the falling edge after the transfer.
    // Valid stays high across back-to-back events, so only drop it when a gap is drawn.
    task automatic push_event(input logic op, input logic [15:0] idx,
                              input logic [7:0] status, input logic [6:0] d1,
                              input logic [6:0] d2);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_event_index <= idx;
        s_status_byte <= status;
        s_data_one    <= d1;
        s_data_two    <= d2;
        // Sample ready at the rising edge; the transfer happens on the first edge it is high.
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(op, idx, status, d1, d2);
        @(negedge aclk);
    endtask

    // Result sink: on a drawn stall, hold ready low until a link waits, then for the stall.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Check every link transfer against the oldest predicted link.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_link(m_first_index, m_second_index, m_link_kind, m_pair_count);
    end

    initial begin : stimulus
        logic [3:0]  chan_pool [4];
        logic [6:0]  key_pool [6];
        logic [3:0]  ch;
        logic [6:0]  key;
        logic [6:0]  ctl;
        int          pick;
        int          live;
        int          drawn;
        int          drain_cycles;

        // Hold reset, then release it; the block then runs its clearing pass with s_ready low.
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: index extremes, both note-off forms, empty pop, full stack, switches.
        push_event(1'b0, 16'h0000, {TYPE_NOTE_ON, 4'h0}, 7'd0, 7'd1);
        push_event(1'b0, 16'hFFFF, {TYPE_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
        push_event(1'b0, 16'h1234, {TYPE_NOTE_ON, 4'hF}, 7'd127, 7'd127);
        push_event(1'b0, 16'hABCD, {TYPE_NOTE_ON, 4'hF}, 7'd127, 7'd0);
        // Note-off with nothing stacked: drop silently.
        push_event(1'b0, 16'h5555, {TYPE_NOTE_OFF, 4'h5}, 7'd10, 7'd64);
        // Five note-ons on one key: the fifth meets a full stack and is flagged.
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            push_event(1'b0, 16'h0100 + 16'(i), {TYPE_NOTE_ON, 4'h3}, 7'(NOTE_KEY_HOLD), 7'd90);
        // Pop pairs with the latest pushed note-on.
        push_event(1'b0, 16'h0200, {TYPE_NOTE_OFF, 4'h3}, 7'(NOTE_KEY_HOLD), 7'd64);
        // Switch off while unknown, on, redundant on, off (link), redundant off.
        push_event(1'b0, 16'h0300, {TYPE_CTRL, 4'h0}, SW_A_LO, 7'd0);
        push_event(1'b0, 16'h0301, {TYPE_CTRL, 4'h0}, SW_A_LO, 7'd127);
        push_event(1'b0, 16'h0302, {TYPE_CTRL, 4'h0}, SW_A_LO, 7'd100);
        push_event(1'b0, 16'h0303, {TYPE_CTRL, 4'h0}, SW_A_LO, SW_THRESHOLD - 7'd1);
        push_event(1'b0, 16'h0304, {TYPE_CTRL, 4'h0}, SW_A_LO, 7'd0);
        push_event(1'b0, 16'h0305, {TYPE_CTRL, 4'hF}, SW_C_CTL, SW_THRESHOLD);
        push_event(1'b0, 16'h0306, {TYPE_CTRL, 4'hF}, SW_B_HI, SW_THRESHOLD);
        push_event(1'b0, 16'h0307, {TYPE_CTRL, 4'hF}, SW_C_CTL, 7'd0);
        // Non-switch controller and other status types: ignored.
        push_event(1'b0, 16'h0400, {TYPE_CTRL, 4'h2}, 7'd70, 7'd127);
        push_event(1'b0, 16'h0401, {TYPE_DATA, 4'h0}, 7'd0, 7'd0);
        push_event(1'b0, 16'h0402, {TYPE_PITCH_BEND, 4'h3}, 7'd1, 7'd2);
        push_event(1'b0, 16'h0403, {TYPE_SYSTEM, 4'hF}, 7'd127, 7'd127);
        // Clear, then confirm stacks and switches came back empty.
        push_event(1'b1, 16'hFFFF, 8'hFF, 7'd127, 7'd127);
        push_event(1'b0, 16'h0500, {TYPE_NOTE_OFF, 4'h3}, 7'(NOTE_KEY_HOLD), 7'd0);
        push_event(1'b0, 16'h0501, {TYPE_CTRL, 4'hF}, SW_B_HI, 7'd0);

        // Random: mostly notes and switches on a few channels and keys so stacks fill up.
        live  = 0;
        drawn = 0;
        while (live < 620) begin
            if (drawn % 40 == 0) begin
                foreach (chan_pool[i]) chan_pool[i] = 4'($urandom);
                foreach (key_pool[i]) key_pool[i] = 7'($urandom);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            drawn++;
            pick = $urandom_range(0, 99);
            ch   = chan_pool[$urandom_range(0, 3)];
            key  = key_pool[$urandom_range(0, 5)];
            if (pick < 40) begin
                push_event(1'b0, 16'($urandom), {TYPE_NOTE_ON, ch}, key,
                           7'($urandom_range(1, 127)));
            end else if (pick < 55) begin
                push_event(1'b0, 16'($urandom), {TYPE_NOTE_OFF, ch}, key, 7'($urandom));
            end else if (pick < 70) begin
                push_event(1'b0, 16'($urandom), {TYPE_NOTE_ON, ch}, key, 7'd0);
            end else if (pick < 90) begin
                pick = $urandom_range(0, 19);
                if (pick < 6)
                    ctl = SW_A_LO + 7'(pick);
                else if (pick < 17)
                    ctl = SW_B_LO + 7'(pick - 6);
                else if (pick == 17)
                    ctl = SW_C_CTL;
                else
                    ctl = 7'($urandom);
                push_event(1'b0, 16'($urandom), {TYPE_CTRL, ch}, ctl, 7'($urandom));
            end else if (pick < 99) begin
                // Noise: any status at all.
                push_event(1'b0, 16'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
            end else begin
                push_event(1'b1, 16'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
            end
            live++;
        end
        s_valid <= 1'b0;

        // Drain: wait for every predicted link, then watch for strays before the final check.
        drain_cycles = 0;
        while (sb.pending_links.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (20) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: report failure and stop if the run has not finished in time.
    initial begin : watchdog
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/mnsl_pkg.sv
rtl/midi_note_and_switch_linker.sv
sim/link_check_pkg.sv
sim/tb_top.sv
